// ===== hdl/pbm_pkg.sv =====
// pbm_pkg: shared types, constants and helpers for the pixel blend pipeline
// no dependencies
package pbm_pkg;

  localparam int unsigned CH_W    = 8;   // color channel width
  localparam int unsigned ALPHA_W = 9;   // alpha / opacity, value over 256
  localparam int unsigned AQ_W    = 17;  // effective alpha in Q16, up to 1.0
  localparam int unsigned BQ_W    = 16;  // blended value with 8 fraction bits
  localparam int unsigned Y_W     = 17;  // scaled channel product
  localparam int unsigned T_W     = 18;  // product plus rounding offset
  localparam int unsigned QT_W    = 10;  // quotient by 255
  localparam int unsigned P1_W    = 25;  // dst times (1 - a)
  localparam int unsigned P2_W    = 33;  // blended times a
  localparam int unsigned SUM_W   = 33;
  localparam int unsigned NSTG    = 5;   // pipeline stages

  localparam logic [AQ_W-1:0]    ALPHA_ONE       = 17'd65536;
  localparam logic [AQ_W-1:0]    ALPHA_THRESHOLD = 17'd655;
  localparam logic [BQ_W-1:0]    FULL_Q8         = 16'd65280;
  localparam logic [ALPHA_W-1:0] FRAC_ONE        = 9'd256;
  localparam logic [CH_W-1:0]    CH_MAX          = 8'd255;
  localparam logic [T_W-1:0]     CEIL_OFS        = 18'd254;
  localparam logic [T_W-1:0]     DIV_255         = 18'd255;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_MULTIPLY = 2'd1,
    MODE_SCREEN   = 2'd2,
    MODE_OVERLAY  = 2'd3
  } mode_e;

  typedef enum logic {
    CFG_MODE    = 1'b0,
    CFG_OPACITY = 1'b1
  } cfg_idx_e;

  // per-lane control: pipeline advance and current blend mode
  typedef struct packed {
    logic  en;
    mode_e mode;
  } pbm_ctrl_t;

  function automatic logic [ALPHA_W-1:0] sat256(input logic [ALPHA_W-1:0] v);
    sat256 = (v > FRAC_ONE) ? FRAC_ONE : v;
  endfunction

endpackage

// ===== hdl/pbm_blend.sv =====
// pbm_blend: three-stage per-channel blend value (Q8) for the selected mode
// depends on pbm_pkg
module pbm_blend import pbm_pkg::*; (
  input  logic            clk_i,
  input  pbm_ctrl_t       ctrl_i,
  input  logic [CH_W-1:0] dst_i,
  input  logic [CH_W-1:0] src_i,
  output logic [BQ_W-1:0] b_o,
  output logic [CH_W-1:0] dst_o
);

  // stage 1: operand selection and 8x8 product
  logic [CH_W-1:0]   inv_s, inv_d, op_x, op_z;
  logic              dbl, use_ceil, invert, pass_src;
  logic [2*CH_W-1:0] prod;
  logic [Y_W-1:0]    y_d;

  logic [Y_W-1:0]  y_q1;
  logic            ceil_q1, inv_q1, norm_q1;
  logic [CH_W-1:0] s_q1, d_q1;

  assign inv_s = CH_MAX - src_i;
  assign inv_d = CH_MAX - dst_i;

  always_comb begin
    op_x     = src_i;
    op_z     = dst_i;
    dbl      = 1'b0;
    use_ceil = 1'b0;
    invert   = 1'b0;
    pass_src = 1'b0;
    unique case (ctrl_i.mode)
      MODE_NORMAL: begin
        pass_src = 1'b1;
      end
      MODE_MULTIPLY: begin
        op_x = src_i;
        op_z = dst_i;
      end
      MODE_SCREEN: begin
        op_x     = inv_s;
        op_z     = inv_d;
        use_ceil = 1'b1;
        invert   = 1'b1;
      end
      MODE_OVERLAY: begin
        dbl = 1'b1;
        // upper half of dst uses the screen-like branch
        if (dst_i[CH_W-1]) begin
          op_x     = inv_s;
          op_z     = inv_d;
          use_ceil = 1'b1;
          invert   = 1'b1;
        end
      end
      default: begin
        pass_src = 1'b1;
      end
    endcase
  end

  assign prod = (2*CH_W)'(op_x) * (2*CH_W)'(op_z);
  assign y_d  = dbl ? {prod, 1'b0} : {1'b0, prod};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      y_q1    <= y_d;
      ceil_q1 <= use_ceil;
      inv_q1  <= invert;
      norm_q1 <= pass_src;
      s_q1    <= src_i;
      d_q1    <= dst_i;
    end
  end

  // stage 2: quotient estimate by 255 via multiply by 257
  // y*256/255 = y + y/255, so only y/255 is needed
  logic [T_W-1:0]    t_d;
  logic [T_W+7:0]    tmul;
  logic [QT_W-1:0]   q0_d;

  logic [T_W-1:0]  t_q2;
  logic [QT_W-1:0] q0_q2;
  logic [Y_W-1:0]  y_q2;
  logic            inv_q2, norm_q2;
  logic [CH_W-1:0] s_q2, d_q2;

  assign t_d  = {1'b0, y_q1} + (ceil_q1 ? CEIL_OFS : '0);
  assign tmul = {t_d, 8'd0} + {8'd0, t_d};
  assign q0_d = tmul[T_W+7:16];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      t_q2    <= t_d;
      q0_q2   <= q0_d;
      y_q2    <= y_q1;
      inv_q2  <= inv_q1;
      norm_q2 <= norm_q1;
      s_q2    <= s_q1;
      d_q2    <= d_q1;
    end
  end

  // stage 3: one-step correction and blended value
  logic [T_W-1:0]  q255, rem;
  logic [QT_W-1:0] quot;
  logic [Y_W-1:0]  qq;
  logic [BQ_W-1:0] b_d;

  logic [BQ_W-1:0] b_q3;
  logic [CH_W-1:0] d_q3;

  assign q255 = {q0_q2, 8'd0} - {8'd0, q0_q2};
  assign rem  = t_q2 - q255;
  assign quot = (rem >= DIV_255) ? q0_q2 + QT_W'(1) : q0_q2;
  assign qq   = y_q2 + Y_W'(quot);

  always_comb begin
    if (norm_q2) begin
      b_d = {s_q2, 8'd0};
    end else if (inv_q2) begin
      b_d = (qq > Y_W'(FULL_Q8)) ? '0 : FULL_Q8 - qq[BQ_W-1:0];
    end else begin
      b_d = (qq > Y_W'(FULL_Q8)) ? FULL_Q8 : qq[BQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      b_q3 <= b_d;
      d_q3 <= d_q2;
    end
  end

  assign b_o   = b_q3;
  assign dst_o = d_q3;

endmodule

// ===== hdl/pbm_mix.sv =====
// pbm_mix: two-stage alpha mix of destination and blended value, one channel
// depends on pbm_pkg
module pbm_mix import pbm_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [AQ_W-1:0] alpha_i,
  input  logic            changed_i,
  input  logic [BQ_W-1:0] b_i,
  input  logic [CH_W-1:0] dst_i,
  output logic [CH_W-1:0] out_o
);

  // stage 4: the two products
  logic [AQ_W-1:0] one_minus_a;
  logic [P1_W-1:0] p1_q;
  logic [P2_W-1:0] p2_q;
  logic [CH_W-1:0] d_q4;

  assign one_minus_a = ALPHA_ONE - alpha_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= P1_W'(dst_i) * P1_W'(one_minus_a);
      p2_q <= P2_W'(b_i) * P2_W'(alpha_i);
      d_q4 <= dst_i;
    end
  end

  // stage 5: sum and take the integer part
  logic [SUM_W-1:0] sum;
  logic [CH_W-1:0]  out_d, out_q;

  assign sum   = {p1_q, 8'd0} + p2_q;
  assign out_d = changed_i ? sum[31:24] : d_q4;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// ===== hdl/pixel_blend_modes_top.sv =====
// pixel_blend_modes_top: five-stage pixel blender, three channel lanes
// depends on pbm_pkg, pbm_blend, pbm_mix
//
// One pixel enters per clock; the whole pipeline advances together, so an output
// stall holds every stage and in_ready_o follows out_ready_i while the
// output register is full. Stage 1 forms the effective alpha (alpha times
// opacity, Q16) and the per-channel 8x8 product, stages 2 and 3 divide by
// 255 with a reciprocal multiply and one correction step, stage 4 holds
// the two mix products and stage 5 the output. Pixels with effective alpha
// at or below 655 come out as the destination with changed_o low. The user
// must write the blend mode and opacity through the cfg port only while
// no pixel is in flight; the block itself does not enforce this.
module pixel_blend_modes_top import pbm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [ALPHA_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CH_W-1:0]    dst_blue_i,
  input  logic [CH_W-1:0]    dst_green_i,
  input  logic [CH_W-1:0]    dst_red_i,
  input  logic [CH_W-1:0]    src_blue_i,
  input  logic [CH_W-1:0]    src_green_i,
  input  logic [CH_W-1:0]    src_red_i,
  input  logic [ALPHA_W-1:0] pixel_alpha_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CH_W-1:0]    out_blue_o,
  output logic [CH_W-1:0]    out_green_o,
  output logic [CH_W-1:0]    out_red_o,
  output logic               changed_o
);

  // configuration registers
  mode_e              mode_q;
  logic [ALPHA_W-1:0] opacity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NORMAL;
      opacity_q <= FRAC_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:    mode_q    <= mode_e'(cfg_data_i[1:0]);
        CFG_OPACITY: opacity_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic            en;
  logic [NSTG-1:0] v_q;
  pbm_ctrl_t       ctrl;

  assign en          = !v_q[NSTG-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[NSTG-1];
  assign ctrl        = '{en: en, mode: mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  // effective alpha and threshold, carried beside the lanes
  logic [AQ_W-1:0]      a_prod;
  logic [AQ_W-1:0]      a_q1, a_q2, a_q3;
  logic [NSTG-1:0]      chg_q;

  assign a_prod = AQ_W'(sat256(pixel_alpha_i)) * AQ_W'(sat256(opacity_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q1 <= a_prod;
      a_q2 <= a_q1;
      a_q3 <= a_q2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chg_q <= '0;
    end else if (en) begin
      chg_q <= {chg_q[NSTG-2:0], (a_prod > ALPHA_THRESHOLD)};
    end
  end

  // channel lanes: blue, green, red
  logic [CH_W-1:0] dst_ch [3];
  logic [CH_W-1:0] src_ch [3];
  logic [CH_W-1:0] res_ch [3];
  logic [BQ_W-1:0] b_ch   [3];
  logic [CH_W-1:0] d3_ch  [3];

  assign dst_ch[0] = dst_blue_i;
  assign dst_ch[1] = dst_green_i;
  assign dst_ch[2] = dst_red_i;
  assign src_ch[0] = src_blue_i;
  assign src_ch[1] = src_green_i;
  assign src_ch[2] = src_red_i;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    pbm_blend u_blend (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .dst_i  (dst_ch[c]),
      .src_i  (src_ch[c]),
      .b_o    (b_ch[c]),
      .dst_o  (d3_ch[c])
    );

    pbm_mix u_mix (
      .clk_i     (clk_i),
      .en_i      (en),
      .alpha_i   (a_q3),
      .changed_i (chg_q[NSTG-2]),
      .b_i       (b_ch[c]),
      .dst_i     (d3_ch[c]),
      .out_o     (res_ch[c])
    );
  end

  assign out_blue_o  = res_ch[0];
  assign out_green_o = res_ch[1];
  assign out_red_o   = res_ch[2];
  assign changed_o   = chg_q[NSTG-1];

  // a stalled result keeps its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_blue_o)
      && $stable(out_green_o) && $stable(out_red_o) && $stable(changed_o))
    else $error("stalled result changed");

  // zero alpha never marks the pixel as blended
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (pixel_alpha_i == '0) |=> !chg_q[0])
    else $error("zero alpha flagged as changed");

  // an accepted item occupies the first stage on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted item lost at stage one");

  // a flagged item carries an effective alpha above threshold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && chg_q[0] |-> (a_q1 > ALPHA_THRESHOLD) && (a_q1 <= ALPHA_ONE))
    else $error("effective alpha out of range for blended item");

endmodule

// ===== dv/tb_pixel_blend_modes_top.sv =====
// tb_pixel_blend_modes_top: self-checking testbench for the pixel blender
// depends on pbm_pkg and pixel_blend_modes_top; predicts each pixel in fixed point
// and checks it in order against the output channel, under random back-pressure
module tb_pixel_blend_modes_top import pbm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ALPHA_UNITY = 65536;
  localparam int unsigned BLEND_GATE  = 655;
  localparam int unsigned Q8_FULL     = 65280;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 130;

  typedef struct packed {
    logic [7:0] dst_b;
    logic [7:0] dst_g;
    logic [7:0] dst_r;
    logic [7:0] src_b;
    logic [7:0] src_g;
    logic [7:0] src_r;
    logic [8:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_b;
    logic [7:0] out_g;
    logic [7:0] out_r;
    logic       changed;
  } result_t;

  typedef struct packed {
    pixel_t     px;
    mode_e      mode;
    logic [8:0] opac;
    logic       typed;
    result_t    want;
  } row_t;

  localparam int unsigned DIR_ROWS = 23;
  localparam row_t DIRECTED [DIR_ROWS] = '{
    // reset settings: normal, full opacity
    '{'{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 9'd256}, MODE_NORMAL, 9'd256, 1'b1,
      '{8'd255, 8'd255, 8'd255, 1'b1}},
    '{'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 9'd256}, MODE_NORMAL, 9'd256, 1'b1,
      '{8'd0, 8'd0, 8'd0, 1'b1}},
    '{'{8'd12, 8'd200, 8'd77, 8'd1, 8'd128, 8'd254, 9'd0}, MODE_NORMAL, 9'd256, 1'b1,
      '{8'd12, 8'd200, 8'd77, 1'b0}},
    // just under the gate
    '{'{8'd255, 8'd0, 8'd170, 8'd0, 8'd255, 8'd85, 9'd2}, MODE_NORMAL, 9'd256, 1'b1,
      '{8'd255, 8'd0, 8'd170, 1'b0}},
    // just over the gate
    '{'{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 9'd3}, MODE_NORMAL, 9'd256, 1'b0, '0},
    // alpha saturates at one
    '{'{8'd9, 8'd99, 8'd199, 8'd200, 8'd100, 8'd50, 9'd511}, MODE_NORMAL, 9'd256, 1'b1,
      '{8'd200, 8'd100, 8'd50, 1'b1}},
    '{'{8'd10, 8'd20, 8'd30, 8'd240, 8'd130, 8'd5, 9'd128}, MODE_NORMAL, 9'd256, 1'b0, '0},
    // opacity saturates at one
    '{'{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 9'd256}, MODE_NORMAL, 9'd511, 1'b1,
      '{8'd4, 8'd5, 8'd6, 1'b1}},
    '{'{8'd255, 8'd128, 8'd127, 8'd0, 8'd1, 8'd2, 9'd256}, MODE_NORMAL, 9'd0, 1'b1,
      '{8'd255, 8'd128, 8'd127, 1'b0}},
    '{'{8'd255, 8'd255, 8'd255, 8'd0, 8'd127, 8'd255, 9'd256}, MODE_MULTIPLY, 9'd256, 1'b1,
      '{8'd0, 8'd127, 8'd255, 1'b1}},
    '{'{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 9'd256}, MODE_MULTIPLY, 9'd256, 1'b1,
      '{8'd0, 8'd0, 8'd0, 1'b1}},
    '{'{8'd100, 8'd127, 8'd128, 8'd200, 8'd50, 8'd255, 9'd200}, MODE_MULTIPLY, 9'd256,
      1'b0, '0},
    '{'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 9'd256}, MODE_SCREEN, 9'd256, 1'b1,
      '{8'd0, 8'd0, 8'd0, 1'b1}},
    '{'{8'd255, 8'd255, 8'd255, 8'd0, 8'd17, 8'd0, 9'd256}, MODE_SCREEN, 9'd256, 1'b1,
      '{8'd255, 8'd255, 8'd255, 1'b1}},
    '{'{8'd60, 8'd127, 8'd200, 8'd30, 8'd128, 8'd250, 9'd100}, MODE_SCREEN, 9'd256,
      1'b0, '0},
    // overlay either side of the dark/light split
    '{'{8'd127, 8'd127, 8'd127, 8'd255, 8'd255, 8'd255, 9'd256}, MODE_OVERLAY, 9'd256,
      1'b0, '0},
    '{'{8'd128, 8'd128, 8'd128, 8'd0, 8'd0, 8'd0, 9'd256}, MODE_OVERLAY, 9'd256, 1'b0, '0},
    '{'{8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 9'd256}, MODE_OVERLAY, 9'd256, 1'b1,
      '{8'd255, 8'd0, 8'd0, 1'b1}},
    '{'{8'd100, 8'd200, 8'd50, 8'd250, 8'd10, 8'd255, 9'd256}, MODE_OVERLAY, 9'd256,
      1'b0, '0},
    '{'{8'd30, 8'd140, 8'd220, 8'd90, 8'd180, 8'd15, 9'd3}, MODE_OVERLAY, 9'd256, 1'b0, '0},
    // low opacity: gate sits between alpha 218 and 219
    '{'{8'd5, 8'd6, 8'd7, 8'd250, 8'd251, 8'd252, 9'd218}, MODE_OVERLAY, 9'd3, 1'b1,
      '{8'd5, 8'd6, 8'd7, 1'b0}},
    '{'{8'd5, 8'd6, 8'd7, 8'd250, 8'd251, 8'd252, 9'd219}, MODE_OVERLAY, 9'd3, 1'b0, '0},
    '{'{8'd200, 8'd60, 8'd140, 8'd10, 8'd255, 8'd128, 9'd511}, MODE_OVERLAY, 9'd3, 1'b0, '0}
  };

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic               cfg_idx_i     = CFG_MODE;
  logic [ALPHA_W-1:0] cfg_data_i    = '0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [CH_W-1:0]    dst_blue_i    = '0;
  logic [CH_W-1:0]    dst_green_i   = '0;
  logic [CH_W-1:0]    dst_red_i     = '0;
  logic [CH_W-1:0]    src_blue_i    = '0;
  logic [CH_W-1:0]    src_green_i   = '0;
  logic [CH_W-1:0]    src_red_i     = '0;
  logic [ALPHA_W-1:0] pixel_alpha_i = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [CH_W-1:0]    out_blue_o;
  logic [CH_W-1:0]    out_green_o;
  logic [CH_W-1:0]    out_red_o;
  logic               changed_o;

  pixel_blend_modes_top dut (.*);

  always #5 clk_i = ~clk_i;

  mode_e       cur_mode    = MODE_NORMAL;
  logic [8:0]  cur_opacity = 9'd256;
  result_t     blend_expect_q [$];
  int unsigned mismatch_cnt  = 0;
  int unsigned stall_cnt     = 0;
  bit          idle_en       = 1'b1;

  function automatic int unsigned blend_q8(mode_e m, int unsigned s, int unsigned d);
    int unsigned p;
    int unsigned q;
    case (m)
      MODE_MULTIPLY: return (s * d * 256) / 255;
      MODE_SCREEN: begin
        p = (255 - s) * (255 - d) * 256;
        q = (p + 254) / 255;
        return (q > Q8_FULL) ? 0 : Q8_FULL - q;
      end
      MODE_OVERLAY: begin
        if (d <= 127) begin
          q = (2 * s * d * 256) / 255;
          return (q > Q8_FULL) ? Q8_FULL : q;
        end
        p = 2 * (255 - s) * (255 - d) * 256;
        q = (p + 254) / 255;
        return (q > Q8_FULL) ? 0 : Q8_FULL - q;
      end
      default: return s * 256;
    endcase
  endfunction

  function automatic int unsigned clip_unity(logic [8:0] v);
    return (v > 9'd256) ? 256 : int'(v);
  endfunction

  function automatic result_t predict_blend(pixel_t px);
    int unsigned       a;
    logic [7:0]        d [3];
    logic [7:0]        s [3];
    logic [7:0]        o [3];
    longint unsigned   mix;
    result_t           r;
    d = '{px.dst_b, px.dst_g, px.dst_r};
    s = '{px.src_b, px.src_g, px.src_r};
    a = clip_unity(px.alpha) * clip_unity(cur_opacity);
    if (a <= BLEND_GATE) begin
      r = '{px.dst_b, px.dst_g, px.dst_r, 1'b0};
      return r;
    end
    for (int c = 0; c < 3; c++) begin
      mix = longint'(d[c]) * 256 * longint'(ALPHA_UNITY - a)
          + longint'(blend_q8(cur_mode, s[c], d[c])) * longint'(a);
      o[c] = mix[31:24];
    end
    r = '{o[0], o[1], o[2], 1'b1};
    return r;
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd127;
      3: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t      px;
    int unsigned op;
    op = clip_unity(cur_opacity);
    px.dst_b = rand_chan();
    px.dst_g = rand_chan();
    px.dst_r = rand_chan();
    px.src_b = rand_chan();
    px.src_g = rand_chan();
    px.src_r = rand_chan();
    case ($urandom_range(0, 9))
      0, 1: px.alpha = 9'($urandom_range(0, 511));
      2: px.alpha = 9'd256;
      3: px.alpha = 9'($urandom_range(250, 262));
      4: begin
        // hunt the gate for the current opacity
        if (op >= 3) px.alpha = 9'(BLEND_GATE / op + $urandom_range(0, 1));
        else px.alpha = 9'($urandom_range(0, 4));
      end
      default: px.alpha = 9'($urandom_range(0, 256));
    endcase
    return px;
  endfunction

  task automatic cfg_write(cfg_idx_e idx, logic [8:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold the input off until every pixel in flight has come out
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (blend_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic apply_setting(mode_e mode, logic [8:0] opac);
    logic [8:0] mode_word;
    if (mode == cur_mode && opac == cur_opacity) return;
    quiesce();
    if (mode != cur_mode) begin
      // upper bits of the mode word are don't-care
      mode_word = {7'($urandom_range(0, 127)), mode};
      cfg_write(CFG_MODE, mode_word);
      cur_mode = mode_e'(mode_word[1:0]);
    end
    if (opac != cur_opacity) begin
      cfg_write(CFG_OPACITY, opac);
      cur_opacity = opac;
    end
  endtask

  task automatic push_pixel(pixel_t px, logic typed, result_t want);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    dst_blue_i    <= px.dst_b;
    dst_green_i   <= px.dst_g;
    dst_red_i     <= px.dst_r;
    src_blue_i    <= px.src_b;
    src_green_i   <= px.src_g;
    src_red_i     <= px.src_r;
    pixel_alpha_i <= px.alpha;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    blend_expect_q.push_back(typed ? want : predict_blend(px));
  endtask

  // output side back-pressure
  initial begin
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (idle_en && $urandom_range(0, 1) == 1) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{out_blue_o, out_green_o, out_red_o, changed_o};
      if (blend_expect_q.size() == 0) begin
        $display("%0t: unexpected item b=%0d g=%0d r=%0d changed=%0d", $realtime,
                 got.out_b, got.out_g, got.out_r, got.changed);
        mismatch_cnt++;
      end else begin
        want = blend_expect_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                   $realtime, want.out_b, want.out_g, want.out_r, want.changed,
                   got.out_b, got.out_g, got.out_r, got.changed);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("pixel_blend_modes_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [8:0] opac;
    mode_e      mode;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      apply_setting(DIRECTED[i].mode, DIRECTED[i].opac);
      push_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      mode = (p < 4) ? mode_e'(p) : mode_e'($urandom_range(0, 3));
      case (p)
        0: opac = 9'd256;
        1: opac = 9'd511;
        2: opac = 9'd3;
        3: opac = 9'd128;
        4: opac = 9'd0;
        5: opac = 9'd1;
        default: opac = 9'($urandom_range(0, 511));
      endcase
      apply_setting(mode, opac);
      // final stretch runs at full rate on both sides
      if (p == PHASES - 1) idle_en = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        push_pixel(rand_pixel(), 1'b0, '0);
        if (p == 3 && n == PHASE_ITEMS / 2) quiesce();
      end
    end

    quiesce();
    if (mismatch_cnt == 0) begin
      $display("pixel_blend_modes_top verification clean");
    end else begin
      $display("pixel_blend_modes_top verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pbm_pkg.sv
hdl/pbm_blend.sv
hdl/pbm_mix.sv
hdl/pixel_blend_modes_top.sv
dv/tb_pixel_blend_modes_top.sv
